### hw/rtl/olir_pkg.sv
// Package: shared constants, codes and types for the ordered list unit.
package olir_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 7;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_QUERY  = 3'd1,
    OP_INSERT = 3'd2,
    OP_READ   = 3'd3,
    OP_REMOVE = 3'd4
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic                      empty;
    logic signed [DATA_W-1:0]  value;
    logic                      last;
    logic [CNT_W-1:0]          count;
  } result_t;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
  } ram_wr_t;

endpackage

### hw/rtl/olir_store.sv
// Element store: one write port, one read port with registered read data.
module olir_store (
  input  logic                          clk,
  input  olir_pkg::ram_wr_t             wr,
  input  logic [olir_pkg::ADDR_W-1:0]   rd_addr,
  output logic [olir_pkg::DATA_W-1:0]   rd_data
);

  logic [olir_pkg::DATA_W-1:0] mem [olir_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/olir_seq.sv
// Sequencer: decodes requests, walks the store with a shared index/compare unit.
module olir_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [olir_pkg::OP_W-1:0]            in_opcode,
  input  logic signed [olir_pkg::DATA_W-1:0]   in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output olir_pkg::result_t                    out_item,
  output logic [olir_pkg::ADDR_W-1:0]          rd_addr,
  input  logic [olir_pkg::DATA_W-1:0]          rd_data,
  output olir_pkg::ram_wr_t                    ram_wr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_REQ,
    S_RD_DATA,
    S_SRCH_REQ,
    S_SRCH_CMP,
    S_SH_REQ,
    S_SH_WR,
    S_EMIT
  } state_t;

  state_t                              state;
  logic [olir_pkg::OP_W-1:0]           op;
  logic [olir_pkg::DATA_W-1:0]         operand;
  logic [olir_pkg::ADDR_W-1:0]         idx;
  logic [olir_pkg::CNT_W-1:0]          count;
  olir_pkg::status_t                   res_status;
  logic [olir_pkg::DATA_W-1:0]         res_value;
  logic                                res_last;

  // shared index unit and comparator
  logic [olir_pkg::CNT_W-1:0] idx_inc;
  logic [olir_pkg::CNT_W-1:0] idx_inc2;
  logic                       at_end;
  logic                       next_is_end;
  logic                       hit;
  logic                       full;

  assign idx_inc     = olir_pkg::CNT_W'(idx) + olir_pkg::CNT_W'(1);
  assign idx_inc2    = idx_inc + olir_pkg::CNT_W'(1);
  assign at_end      = (idx_inc == count);
  assign next_is_end = (idx_inc2 == count);
  assign hit         = (rd_data == operand);
  assign full        = (count >= olir_pkg::CNT_W'(olir_pkg::CAPACITY));

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);

  assign out_item.status = res_status;
  assign out_item.empty  = (count == '0);
  assign out_item.value  = res_value;
  assign out_item.last   = res_last;
  assign out_item.count  = count;

  assign rd_addr = (state == S_SH_REQ) ? idx_inc[olir_pkg::ADDR_W-1:0] : idx;

  always_comb begin
    ram_wr = '0;
    if (state == S_IDLE && in_valid && in_opcode == olir_pkg::OP_INSERT && !full) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = count[olir_pkg::ADDR_W-1:0];
      ram_wr.data = in_value;
    end else if (state == S_SH_WR) begin
      ram_wr.en   = 1'b1;
      ram_wr.addr = idx;
      ram_wr.data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      idx        <= '0;
      op         <= '0;
      res_status <= olir_pkg::STAT_OK;
      res_last   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= in_opcode;
            operand   <= in_value;
            idx       <= '0;
            res_value <= '0;
            res_last  <= 1'b1;
            unique case (in_opcode)
              olir_pkg::OP_CLEAR: begin
                res_status <= olir_pkg::STAT_OK;
                count      <= '0;
                state      <= S_EMIT;
              end
              olir_pkg::OP_QUERY: begin
                res_status <= olir_pkg::STAT_OK;
                state      <= S_EMIT;
              end
              olir_pkg::OP_INSERT: begin
                if (full) begin
                  res_status <= olir_pkg::STAT_FULL;
                end else begin
                  res_status <= olir_pkg::STAT_OK;
                  count      <= count + olir_pkg::CNT_W'(1);
                end
                state <= S_EMIT;
              end
              olir_pkg::OP_READ: begin
                if (count == '0) begin
                  res_status <= olir_pkg::STAT_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  res_status <= olir_pkg::STAT_OK;
                  state      <= S_RD_REQ;
                end
              end
              olir_pkg::OP_REMOVE: begin
                if (count == '0) begin
                  res_status <= olir_pkg::STAT_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  res_status <= olir_pkg::STAT_OK;
                  state      <= S_SRCH_REQ;
                end
              end
              default: begin
                // unused opcode: word dropped, nothing emitted
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD_REQ: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          res_status <= olir_pkg::STAT_OK;
          res_value  <= rd_data;
          res_last   <= at_end;
          state      <= S_EMIT;
        end
        S_SRCH_REQ: begin
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (hit) begin
            if (at_end) begin
              count      <= count - olir_pkg::CNT_W'(1);
              res_status <= olir_pkg::STAT_OK;
              state      <= S_EMIT;
            end else begin
              state <= S_SH_REQ;
            end
          end else if (at_end) begin
            res_status <= olir_pkg::STAT_NOT_FOUND;
            state      <= S_EMIT;
          end else begin
            idx   <= idx_inc[olir_pkg::ADDR_W-1:0];
            state <= S_SRCH_REQ;
          end
        end
        S_SH_REQ: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          // entry idx takes entry idx+1
          idx <= idx_inc[olir_pkg::ADDR_W-1:0];
          if (next_is_end) begin
            count      <= count - olir_pkg::CNT_W'(1);
            res_status <= olir_pkg::STAT_OK;
            state      <= S_EMIT;
          end else begin
            state <= S_SH_REQ;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (op == olir_pkg::OP_READ && res_status == olir_pkg::STAT_OK && !res_last) begin
              idx   <= idx_inc[olir_pkg::ADDR_W-1:0];
              state <= S_RD_REQ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= olir_pkg::CNT_W'(olir_pkg::CAPACITY))
    else $error("element count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(count)) |->
      (count == $past(count) + olir_pkg::CNT_W'(1) ||
       count == $past(count) - olir_pkg::CNT_W'(1) || count == '0))
    else $error("count moved by more than one");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && res_status == olir_pkg::STAT_FULL) |->
      count == olir_pkg::CNT_W'(olir_pkg::CAPACITY))
    else $error("full reported below capacity");

  a_read_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && op == olir_pkg::OP_READ && res_status == olir_pkg::STAT_OK) |->
      (res_last == at_end))
    else $error("read-out last marker misplaced");

  a_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_wr.en |->
      ((state == S_IDLE && in_valid &&
        count < olir_pkg::CNT_W'(olir_pkg::CAPACITY)) ||
       state == S_SH_WR))
    else $error("store written outside insert or compaction");

endmodule

### hw/rtl/olir_obuf.sv
// Output register stage between the sequencer and the master port.
module olir_obuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  olir_pkg::result_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output olir_pkg::result_t  out_item
);

  logic              valid;
  olir_pkg::result_t item;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

### hw/rtl/ordered_list_insert_remove_unit.sv
// Top level: bounded ordered list with tail insert and remove by value.
//
//  channel   dir  signals                         content
//  s_*       in   tvalid tready tdata tuser       one request word
//  m_*       out  tvalid tready tdata tuser tlast one result word
//
// Clear, query and insert are decoded, then handed off to the output register.
// Read-out is decoded, then walks S_RD_REQ, S_RD_DATA and S_EMIT for each element,
// plus any stall on m_tready. Remove searches (S_SRCH_REQ, S_SRCH_CMP), then moves
// later entries up (S_SH_REQ, S_SH_WR) through the store read port walked by the sequencer.
// s_tready is high only while the sequencer is idle; reset (rst, sync)
// empties the list; the store itself is not cleared.
module ordered_list_insert_remove_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] operand_value
  input  logic [2:0]  s_tuser,   // [2:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] element_value, [38:32] element_count, [39] zero
  output logic [2:0]  m_tuser,   // [1:0] status, [2] empty_flag
  output logic        m_tlast    // last_flag
);

  logic                              seq_valid;
  logic                              seq_ready;
  olir_pkg::result_t                 seq_item;
  olir_pkg::result_t                 buf_item;
  logic [olir_pkg::ADDR_W-1:0]       rd_addr;
  logic [olir_pkg::DATA_W-1:0]       rd_data;
  olir_pkg::ram_wr_t                 ram_wr;

  olir_store u_store (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  olir_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_opcode (s_tuser),
    .in_value  (s_tdata),
    .out_valid (seq_valid),
    .out_ready (seq_ready),
    .out_item  (seq_item),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .ram_wr    (ram_wr)
  );

  olir_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (seq_valid),
    .in_ready  (seq_ready),
    .in_item   (seq_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (buf_item)
  );

  assign m_tdata = {1'b0, buf_item.count, buf_item.value};
  assign m_tuser = {buf_item.empty, buf_item.status};
  assign m_tlast = buf_item.last;

endmodule
